@@ sv/wfpb_pkg.sv @@
// ----------------------------------------------------------------------------
// wfpb_pkg
// Shared types, constants and helpers for the wrapping five-point blur unit.
// ----------------------------------------------------------------------------
package wfpb_pkg;

    localparam int PIX_W      = 8;   // grey value width
    localparam int CFG_W      = 9;   // side_length register width
    localparam int SIDE_RESET = 32;  // side_length after reset
    localparam int TAP_W      = 3;

    // request codes carried by req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // read order of the five stencil taps
    localparam logic [TAP_W-1:0] TAP_CENTER = 3'd0;
    localparam logic [TAP_W-1:0] TAP_LEFT   = 3'd1;
    localparam logic [TAP_W-1:0] TAP_UP     = 3'd2;
    localparam logic [TAP_W-1:0] TAP_RIGHT  = 3'd3;
    localparam logic [TAP_W-1:0] TAP_DOWN   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FINISH,
        S_HOLD
    } t_state;

    // floor(v / 5) for 8-bit v: multiply by 205, drop 10 bits
    function automatic logic [5:0] div5(input logic [PIX_W-1:0] v);
        logic [15:0] p;
        p = {8'd0, v} * 16'd205;
        return p[15:10];
    endfunction

endpackage

@@ sv/wfpb_ram.sv @@
// ----------------------------------------------------------------------------
// wfpb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wfpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wrapping_five_point_blur_unit.sv @@
// ----------------------------------------------------------------------------
// wrapping_five_point_blur_unit
// Toroidal five-point box blur over a square 8-bit grey image held in a
// single frame memory.
//
// A load transfer (req_type 0) writes one pixel into the frame memory at the
// next raster position; it produces no output. A drain transfer (req_type 1)
// produces the next blurred pixel in raster order: the centre pixel and its
// left, up, right and down neighbours, each divided by 5 on its own and
// summed, with neighbours wrapping at the image edges. The single read port
// of the frame memory sets the drain time: five reads, one per cycle, the
// first issued in the accept cycle; the unit then stays busy until the result
// enters the output register, longer while a previous result still waits.
// Loads are taken while a result waits. Writing side_length (0 acts as 1,
// values above MAX_SIDE saturate) rewinds both the load and the drain
// position; write it only while the unit is idle. The frame memory has no
// reset; drain only pixels of a fully loaded image.
// ----------------------------------------------------------------------------
module wrapping_five_point_blur_unit
    import wfpb_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_side_length_we,
    input  logic [CFG_W-1:0] i_side_length,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  logic [PIX_W-1:0] i_pixel_in,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_blurred_pixel,
    output logic             o_last_pixel
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);         // linear pixel address
    localparam int SW    = $clog2(MAX_SIDE + 1);  // side value
    localparam int XBW   = $clog2(MAX_SIDE);      // column index
    localparam int XW    = (SW > CFG_W) ? SW : CFG_W;
    localparam int RST_S = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

    // ------------------------------------------------------------------
    // Configuration: clamp the side, precompute count-1 and last row base
    // ------------------------------------------------------------------
    logic [XW-1:0]     w_cfg_ext;
    logic [XW-1:0]     w_cfg_cl;
    logic [SW-1:0]     w_cfg_side;
    logic [2*SW-1:0]   w_cfg_sq;
    logic [2*SW-1:0]   w_cfg_lb;

    assign w_cfg_ext = XW'(i_side_length);

    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cfg_cl = XW'(1);
        end else if (w_cfg_ext > XW'(MAX_SIDE)) begin
            w_cfg_cl = XW'(MAX_SIDE);
        end else begin
            w_cfg_cl = w_cfg_ext;
        end
    end

    assign w_cfg_side = SW'(w_cfg_cl);
    assign w_cfg_sq   = (2*SW)'(w_cfg_side) * (2*SW)'(w_cfg_side);
    assign w_cfg_lb   = (2*SW)'(w_cfg_side) * (2*SW)'(w_cfg_side - SW'(1));

    logic [XBW-1:0] r_side_m1;   // side - 1
    logic [AW-1:0]  r_count_m1;  // side*side - 1
    logic [AW-1:0]  r_last_base; // (side-1)*side, start of the bottom row

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [TAP_W-1:0]  r_k;
    logic              r_pend;      // a read was issued last cycle
    logic [PIX_W-1:0]  r_sum;
    logic              r_last;

    logic [AW-1:0]     r_lpos;      // next load position
    logic [AW-1:0]     r_dpos;      // next drain position
    logic [XBW-1:0]    r_dx;        // its column
    logic [AW-1:0]     r_dbase;     // its row start, y*side

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_last;

    logic              w_in_xfer;
    logic              w_load;
    logic              w_drain;
    logic              w_out_free;
    logic              w_out_load;
    logic [PIX_W-1:0]  w_out_data;
    logic              w_read_done;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_load      = w_in_xfer && (i_req_type == REQ_LOAD);
    assign w_drain     = w_in_xfer && (i_req_type == REQ_DRAIN);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_read_done = (r_state == S_READ) && (r_k == TAP_DOWN);

    // ------------------------------------------------------------------
    // Stencil addressing: wrap columns and rows around the torus
    // ------------------------------------------------------------------
    logic [XBW-1:0]   w_xl, w_xr;
    logic [AW-1:0]    w_side_a;
    logic [AW-1:0]    w_base_up, w_base_dn;
    logic [TAP_W-1:0] w_sel;
    logic [AW-1:0]    w_raddr;
    logic [PIX_W-1:0] w_rdata;
    logic [PIX_W-1:0] w_total;

    assign w_xl      = (r_dx == '0) ? r_side_m1 : r_dx - XBW'(1);
    assign w_xr      = (r_dx == r_side_m1) ? '0 : r_dx + XBW'(1);
    assign w_side_a  = AW'(r_side_m1) + AW'(1);
    assign w_base_up = (r_dbase == '0) ? r_last_base : r_dbase - w_side_a;
    assign w_base_dn = (r_dbase == r_last_base) ? '0 : r_dbase + w_side_a;

    // first tap goes out in the accept cycle
    assign w_sel = (r_state == S_READ) ? r_k : TAP_CENTER;

    always_comb begin
        unique case (w_sel)
            TAP_CENTER: w_raddr = r_dbase + AW'(r_dx);
            TAP_LEFT:   w_raddr = r_dbase + AW'(w_xl);
            TAP_UP:     w_raddr = w_base_up + AW'(r_dx);
            TAP_RIGHT:  w_raddr = r_dbase + AW'(w_xr);
            TAP_DOWN:   w_raddr = w_base_dn + AW'(r_dx);
            default:    w_raddr = r_dbase + AW'(r_dx);
        endcase
    end

    wfpb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_lpos),
        .i_wdata (i_pixel_in),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // each term is at most 51, five of them never exceed 255
    assign w_total = r_sum + PIX_W'(div5(w_rdata));

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        w_out_data = r_sum;
        unique case (r_state)
            S_IDLE: begin
                if (w_drain) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_k == TAP_DOWN) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // last term arrives now
                w_out_data = w_total;
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Tap sequencing and accumulation
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= TAP_CENTER;
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_drain || (r_state == S_READ);
            if (w_drain) begin
                r_k <= TAP_LEFT;
            end else if (r_state == S_READ) begin
                r_k <= r_k + TAP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_sum  <= '0;
            r_last <= (r_dpos == r_count_m1);
        end else if (r_pend) begin
            r_sum <= w_total;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and raster positions
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_m1   <= XBW'(RST_S - 1);
            r_count_m1  <= AW'(RST_S * RST_S - 1);
            r_last_base <= AW'(RST_S * (RST_S - 1));
            r_lpos      <= '0;
            r_dpos      <= '0;
            r_dx        <= '0;
            r_dbase     <= '0;
        end else if (i_side_length_we) begin
            r_side_m1   <= XBW'(w_cfg_side - SW'(1));
            r_count_m1  <= AW'(w_cfg_sq - (2*SW)'(1));
            r_last_base <= AW'(w_cfg_lb);
            r_lpos      <= '0;
            r_dpos      <= '0;
            r_dx        <= '0;
            r_dbase     <= '0;
        end else begin
            if (w_load) begin
                r_lpos <= (r_lpos == r_count_m1) ? '0 : r_lpos + AW'(1);
            end
            // step the drain position once all five taps are out
            if (w_read_done) begin
                if (r_dpos == r_count_m1) begin
                    r_dpos  <= '0;
                    r_dx    <= '0;
                    r_dbase <= '0;
                end else if (r_dx == r_side_m1) begin
                    r_dpos  <= r_dpos + AW'(1);
                    r_dx    <= '0;
                    r_dbase <= w_base_dn;
                end else begin
                    r_dpos <= r_dpos + AW'(1);
                    r_dx   <= r_dx + XBW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pixel <= w_out_data;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_blurred_pixel = r_out_pixel;
    assign o_last_pixel    = r_out_last;

endmodule
